>>> rtl/core/dkv_pkg.sv
// shared types and constants for the delimited key/value extractor
// no dependencies; imported by every rtl/core module
`timescale 1ns / 1ps
`default_nettype none

package dkv_pkg;

    localparam logic [7:0]  DELIM_FIRST      = 8'hC0;
    localparam logic [7:0]  DELIM_SECOND     = 8'h80;
    localparam logic [7:0]  KEY_SEND         = 8'h31;
    localparam logic [7:0]  KEY_RECV         = 8'h34;
    localparam logic [7:0]  KEY_TO           = 8'h35;
    localparam logic [15:0] KEY_MSG          = 16'h3431;

    localparam int          NAME_W           = 8;
    localparam int          TEXT_W           = 12;
    localparam int          CFG_IDX_W        = 2;
    localparam int          CFG_DATA_W       = 12;

    localparam logic [NAME_W-1:0] NAME_LIMIT_RESET = 8'd60;
    localparam logic [TEXT_W-1:0] TEXT_LIMIT_RESET = 12'd810;

    localparam logic [CFG_IDX_W-1:0] REG_NAME_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_LIMIT = 2'd1;

    localparam logic [1:0]  KIND_SENDER      = 2'd0;
    localparam logic [1:0]  KIND_RECEIVER    = 2'd1;
    localparam logic [1:0]  KIND_TEXT        = 2'd2;
    localparam logic [1:0]  KIND_END         = 2'd3;
    localparam logic [1:0]  KIND_IGNORE      = 2'd3;

    localparam int          QUEUE_DEPTH      = 4;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic       status;
        logic [2:0] mask;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/dkv_front.sv
// byte parser: delimiter scan, key decode, limits and end-of-body status
// depends on dkv_pkg; produces at most one result per accepted byte
`timescale 1ns / 1ps
`default_nettype none

module dkv_front (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_take,
    input  wire  [7:0]                    i_data_byte,
    input  wire                           i_last_byte,
    input  wire                           i_cfg_we,
    input  wire  [dkv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [dkv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_push,
    output dkv_pkg::t_result              o_result
);
    import dkv_pkg::*;

    logic [NAME_W-1:0] r_name_limit;
    logic [TEXT_W-1:0] r_text_limit;

    logic [7:0]        r_held_byte,  n_held_byte;
    logic              r_held_valid, n_held_valid;
    logic              r_in_value,   n_in_value;
    logic [15:0]       r_key_bytes,  n_key_bytes;
    logic [1:0]        r_key_count,  n_key_count;
    logic [1:0]        r_value_kind, n_value_kind;
    logic [1:0]        r_pair_count, n_pair_count;
    logic [2:0]        r_seen,       n_seen;
    logic [NAME_W-1:0] r_name_count, n_name_count;
    logic [TEXT_W-1:0] r_text_count, n_text_count;

    logic              is_delim;
    logic [1:0]        new_kind;
    logic [7:0]        key_first;
    logic              emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_name_limit <= NAME_LIMIT_RESET;
            r_text_limit <= TEXT_LIMIT_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_NAME_LIMIT) begin
                r_name_limit <= i_cfg_data[NAME_W-1:0];
            end else if (i_cfg_idx == REG_TEXT_LIMIT) begin
                r_text_limit <= i_cfg_data[TEXT_W-1:0];
            end
        end
    end

    assign key_first = r_key_bytes[7:0];
    assign is_delim  = r_held_valid && (r_held_byte == DELIM_FIRST)
                       && (i_data_byte == DELIM_SECOND);

    always_comb begin
        if (r_key_count == 2'd1 && !r_seen[0]
            && (key_first == KEY_SEND || key_first == KEY_RECV)) begin
            new_kind = KIND_SENDER;
        end else if (r_key_count == 2'd1 && !r_seen[1] && key_first == KEY_TO) begin
            new_kind = KIND_RECEIVER;
        end else if (r_key_count == 2'd2 && r_key_bytes == KEY_MSG) begin
            new_kind = KIND_TEXT;
        end else begin
            new_kind = KIND_IGNORE;
        end
    end

    always_comb begin
        n_held_byte  = r_held_byte;
        n_held_valid = r_held_valid;
        n_in_value   = r_in_value;
        n_key_bytes  = r_key_bytes;
        n_key_count  = r_key_count;
        n_value_kind = r_value_kind;
        n_pair_count = (r_pair_count == 2'd3) ? 2'd3 : r_pair_count + 2'd1;
        n_seen       = r_seen;
        n_name_count = r_name_count;
        n_text_count = r_text_count;
        emit         = 1'b0;

        if (is_delim) begin
            n_held_valid = 1'b0;
            if (!r_in_value) begin
                if (new_kind != KIND_IGNORE) begin
                    n_seen = r_seen | (3'b001 << new_kind);
                end
                n_value_kind = new_kind;
                n_name_count = '0;
                n_in_value   = 1'b1;
            end else begin
                n_in_value   = 1'b0;
                n_key_bytes  = '0;
                n_key_count  = '0;
                n_value_kind = KIND_IGNORE;
                n_pair_count = '0;
            end
        end else begin
            if (r_held_valid) begin
                if (!r_in_value) begin
                    if (r_key_count == 2'd0) begin
                        n_key_bytes = {8'h00, r_held_byte};
                    end else if (r_key_count == 2'd1) begin
                        n_key_bytes = {r_held_byte, r_key_bytes[7:0]};
                    end
                    if (r_key_count != 2'd3) begin
                        n_key_count = r_key_count + 2'd1;
                    end
                end else if (r_value_kind == KIND_SENDER || r_value_kind == KIND_RECEIVER) begin
                    if (r_name_count < r_name_limit) begin
                        n_name_count = r_name_count + 8'd1;
                        emit         = 1'b1;
                    end
                end else if (r_value_kind == KIND_TEXT) begin
                    if (r_text_count < r_text_limit) begin
                        n_text_count = r_text_count + 12'd1;
                        emit         = 1'b1;
                    end
                end
            end
            n_held_byte  = i_data_byte;
            n_held_valid = 1'b1;
        end

        o_result.kind   = r_value_kind;
        o_result.data   = r_held_byte;
        o_result.status = 1'b0;
        o_result.mask   = '0;
        o_push          = i_take && emit;

        // end of body wins over a released byte and clears body state
        if (i_last_byte) begin
            o_result.kind   = KIND_END;
            o_result.data   = '0;
            o_result.status = (n_pair_count > 2'd2);
            o_result.mask   = (n_pair_count > 2'd2) ? 3'b000 : n_seen;
            o_push          = i_take;
            n_held_byte     = '0;
            n_held_valid    = 1'b0;
            n_in_value      = 1'b0;
            n_key_bytes     = '0;
            n_key_count     = '0;
            n_value_kind    = KIND_IGNORE;
            n_pair_count    = '0;
            n_seen          = '0;
            n_name_count    = '0;
            n_text_count    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_byte  <= '0;
            r_held_valid <= 1'b0;
            r_in_value   <= 1'b0;
            r_key_bytes  <= '0;
            r_key_count  <= '0;
            r_value_kind <= KIND_IGNORE;
            r_pair_count <= '0;
            r_seen       <= '0;
            r_name_count <= '0;
            r_text_count <= '0;
        end else if (i_take) begin
            r_held_byte  <= n_held_byte;
            r_held_valid <= n_held_valid;
            r_in_value   <= n_in_value;
            r_key_bytes  <= n_key_bytes;
            r_key_count  <= n_key_count;
            r_value_kind <= n_value_kind;
            r_pair_count <= n_pair_count;
            r_seen       <= n_seen;
            r_name_count <= n_name_count;
            r_text_count <= n_text_count;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/dkv_queue.sv
// result queue between parser and output channel, registered head
// depends on dkv_pkg for the result type
`timescale 1ns / 1ps
`default_nettype none

module dkv_queue #(
    parameter int P_DEPTH = 4
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  dkv_pkg::t_result  i_result,
    output logic              o_full,
    output logic              o_valid,
    input  wire               i_ready,
    output dkv_pkg::t_result  o_result
);
    import dkv_pkg::*;

    localparam int PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(P_DEPTH);

    t_result           r_mem [P_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              pop;

    assign o_full   = (r_count == FULL_CNT);
    assign o_valid  = (r_count != '0);
    assign pop      = o_valid && i_ready;
    assign o_result = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/delimited_key_value_extractor.sv
// a result is written into the output queue at the accepting edge and is valid from the next cycle
// throughput: one byte per cycle, limited only by the output queue filling when stalled
// a value byte shows up one byte late, once its successor rules out a delimiter
// synchronous active-low reset clears parse state and queue; limits return to 60 and 810
// depends on dkv_pkg, dkv_front and dkv_queue
`timescale 1ns / 1ps
`default_nettype none

module delimited_key_value_extractor #(
    parameter int P_QUEUE_DEPTH = dkv_pkg::QUEUE_DEPTH
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_valid,
    output logic                          o_ready,
    input  wire  [7:0]                    i_data_byte,
    input  wire                           i_last_byte,
    input  wire                           i_cfg_we,
    input  wire  [dkv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire  [dkv_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_valid,
    input  wire                           i_ready,
    output logic [1:0]                    o_out_kind,
    output logic [7:0]                    o_out_byte,
    output logic                          o_end_status,
    output logic [2:0]                    o_found_mask
);
    import dkv_pkg::*;

    logic    take;
    logic    push;
    logic    full;
    t_result front_result;
    t_result head;

    assign o_ready = !full;
    assign take    = i_valid && o_ready;

    dkv_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_push      (push),
        .o_result    (front_result)
    );

    dkv_queue #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_result (front_result),
        .o_full   (full),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (head)
    );

    assign o_out_kind   = head.kind;
    assign o_out_byte   = head.data;
    assign o_end_status = head.status;
    assign o_found_mask = head.mask;

endmodule

`default_nettype wire

>>> rtl/core/dkv_checker.sv
// port-level checks for the extractor, bound to the top level
// depends on dkv_pkg and delimited_key_value_extractor
`timescale 1ns / 1ps
`default_nettype none

module dkv_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_valid,
    input wire       i_ready,
    input wire [1:0] o_out_kind,
    input wire [7:0] o_out_byte,
    input wire       o_end_status,
    input wire [2:0] o_found_mask
);
    import dkv_pkg::*;

    // a waiting item is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid)
        else $error("output item dropped while stalled");

    // queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // value items carry no status or mask
    a_value_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind != KIND_END) |-> !o_end_status && (o_found_mask == 3'b000))
        else $error("value item with end fields set");

    // end item: zero byte, and an error end reports nothing found
    a_end_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_out_kind == KIND_END) |->
            (o_out_byte == 8'h00) && (!o_end_status || (o_found_mask == 3'b000)))
        else $error("malformed end item");

endmodule

bind delimited_key_value_extractor dkv_checker u_dkv_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_ready      (i_ready),
    .o_out_kind   (o_out_kind),
    .o_out_byte   (o_out_byte),
    .o_end_status (o_end_status),
    .o_found_mask (o_found_mask)
);

`default_nettype wire

>>> sim/tb_top.sv
// self-checking bench for delimited_key_value_extractor: byte stream in, tagged value items out
// depends on dkv_pkg and the rtl/core sources; tracks the parser state itself to predict items
`timescale 1ns / 1ps

module tb_top;
    import dkv_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [7:0] data;
        logic       last;
        bit         typed;
        t_result    want;
    } t_opening_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic [7:0]            i_data_byte = 8'h00;
    logic                  i_last_byte = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = REG_NAME_LIMIT;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [1:0]            o_out_kind;
    logic [7:0]            o_out_byte;
    logic                  o_end_status;
    logic [2:0]            o_found_mask;

    // parser state as the block should hold it
    logic [7:0]  body_held_byte;
    bit          body_held_valid;
    bit          body_in_value;
    logic [15:0] body_key_bytes;
    logic [1:0]  body_key_count;
    logic [1:0]  body_value_kind;
    logic [1:0]  body_pair_count;
    logic [2:0]  body_seen;
    logic [7:0]  body_name_count;
    logic [11:0] body_text_count;
    logic [7:0]  cur_name_limit = NAME_LIMIT_RESET;
    logic [11:0] cur_text_limit = TEXT_LIMIT_RESET;

    t_result expected_results[$];
    t_result rx_want;
    int      fail_count = 0;
    int      burst_left = 0;
    int      rx_stall_pct = 0;
    int      rx_stretch = 0;
    bit      pressure_go = 1'b0;
    logic    hold_off = 1'b0;

    // sender, receiver, text, end of body
    t_opening_row opening_bytes [26] = '{
        '{8'h00, 1'b1, 1'b1, {KIND_END, 8'h00, 1'b0, 3'b000}},
        '{8'h31, 1'b0, 1'b0, '0},
        '{8'hC0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'hFF, 1'b0, 1'b1, {KIND_SENDER, 8'h41, 1'b0, 3'b000}},
        '{8'hC0, 1'b0, 1'b1, {KIND_SENDER, 8'hFF, 1'b0, 3'b000}},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h35, 1'b0, 1'b0, '0},
        '{8'hC0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0},
        '{8'hC0, 1'b0, 1'b1, {KIND_RECEIVER, 8'h00, 1'b0, 3'b000}},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h31, 1'b0, 1'b0, '0},
        '{8'h34, 1'b0, 1'b0, '0},
        '{8'hC0, 1'b0, 1'b0, '0},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'hC0, 1'b0, 1'b0, '0},
        '{8'hC0, 1'b0, 1'b1, {KIND_TEXT, 8'hC0, 1'b0, 3'b000}},
        '{8'h80, 1'b0, 1'b0, '0},
        '{8'h7A, 1'b0, 1'b0, '0},
        '{8'h00, 1'b1, 1'b1, {KIND_END, 8'h00, 1'b0, 3'b111}},
        '{8'h41, 1'b0, 1'b0, '0},
        '{8'h42, 1'b0, 1'b0, '0},
        '{8'h43, 1'b1, 1'b1, {KIND_END, 8'h00, 1'b1, 3'b000}}
    };

    delimited_key_value_extractor uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_kind   (o_out_kind),
        .o_out_byte   (o_out_byte),
        .o_end_status (o_end_status),
        .o_found_mask (o_found_mask)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        fail_count++;
    endtask

    task automatic clear_body();
        body_held_byte  = 8'h00;
        body_held_valid = 1'b0;
        body_in_value   = 1'b0;
        body_key_bytes  = 16'h0000;
        body_key_count  = 2'd0;
        body_value_kind = KIND_IGNORE;
        body_pair_count = 2'd0;
        body_seen       = 3'b000;
        body_name_count = 8'd0;
        body_text_count = 12'd0;
    endtask

    task automatic track_body_byte(input logic [7:0] b, input logic last,
                                   output bit got, output t_result res);
        logic [1:0] kind;
        bit         bad;
        got = 1'b0;
        res = '0;
        if (body_pair_count < 2'd3) body_pair_count++;
        if (body_held_valid && body_held_byte == DELIM_FIRST && b == DELIM_SECOND) begin
            body_held_valid = 1'b0;
            if (!body_in_value) begin
                kind = KIND_IGNORE;
                if (body_key_count == 2'd1 && !body_seen[0] &&
                    (body_key_bytes[7:0] == KEY_SEND || body_key_bytes[7:0] == KEY_RECV)) begin
                    kind = KIND_SENDER;
                end else if (body_key_count == 2'd1 && !body_seen[1] &&
                             body_key_bytes[7:0] == KEY_TO) begin
                    kind = KIND_RECEIVER;
                end else if (body_key_count == 2'd2 && body_key_bytes == KEY_MSG) begin
                    kind = KIND_TEXT;
                end
                if (kind != KIND_IGNORE) body_seen[kind] = 1'b1;
                body_value_kind = kind;
                body_name_count = 8'd0;
                body_in_value   = 1'b1;
            end else begin
                body_in_value   = 1'b0;
                body_key_bytes  = 16'h0000;
                body_key_count  = 2'd0;
                body_value_kind = KIND_IGNORE;
                body_pair_count = 2'd0;
            end
        end else begin
            // the held byte is not a delimiter start, so it goes out now
            if (body_held_valid) begin
                if (!body_in_value) begin
                    if (body_key_count == 2'd0) body_key_bytes = {8'h00, body_held_byte};
                    else if (body_key_count == 2'd1) body_key_bytes[15:8] = body_held_byte;
                    if (body_key_count < 2'd3) body_key_count++;
                end else if (body_value_kind == KIND_SENDER ||
                             body_value_kind == KIND_RECEIVER) begin
                    if (body_name_count < cur_name_limit) begin
                        body_name_count++;
                        got = 1'b1;
                    end
                end else if (body_value_kind == KIND_TEXT) begin
                    if (body_text_count < cur_text_limit) begin
                        body_text_count++;
                        got = 1'b1;
                    end
                end
                if (got) begin
                    res.kind = body_value_kind;
                    res.data = body_held_byte;
                end
            end
            body_held_byte  = b;
            body_held_valid = 1'b1;
        end
        if (last) begin
            bad        = (body_pair_count > 2'd2);
            got        = 1'b1;
            res.kind   = KIND_END;
            res.data   = 8'h00;
            res.status = bad;
            res.mask   = bad ? 3'b000 : body_seen;
            clear_body();
        end
    endtask

    // offer one item in bursts with random gaps, predict at the accepting edge
    task automatic feed_byte(input logic [7:0] d, input logic last,
                             output bit got, output t_result res);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid     <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= last;
        do @(posedge i_clk); while (!o_ready);
        track_body_byte(d, last, got, res);
    endtask

    task automatic set_limits(input logic [7:0] name_lim, input logic [11:0] text_lim,
                              input bit poke_unused);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_NAME_LIMIT;
        i_cfg_data <= {4'h0, name_lim};
        @(posedge i_clk);
        cur_name_limit = name_lim;
        i_cfg_idx  <= REG_TEXT_LIMIT;
        i_cfg_data <= text_lim;
        @(posedge i_clk);
        cur_text_limit = text_lim;
        if (poke_unused) begin
            i_cfg_idx  <= REG_UNUSED;
            i_cfg_data <= 12'($urandom);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    // receiver: stall rate changes from stretch to stretch
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf("unexpected item kind %0d byte %02h status %0b mask %03b",
                                        o_out_kind, o_out_byte, o_end_status, o_found_mask));
            end else begin
                rx_want = expected_results.pop_front();
                if (o_out_kind !== rx_want.kind || o_out_byte !== rx_want.data ||
                    o_end_status !== rx_want.status || o_found_mask !== rx_want.mask) begin
                    note_mismatch($sformatf({"got kind %0d byte %02h status %0b mask %03b, ",
                                             "want kind %0d byte %02h status %0b mask %03b"},
                                            o_out_kind, o_out_byte, o_end_status, o_found_mask,
                                            rx_want.kind, rx_want.data, rx_want.status,
                                            rx_want.mask));
                end
            end
        end
        if (rx_stretch == 0) begin
            rx_stretch = $urandom_range(40, 300);
            case ($urandom_range(0, 3))
                0:       rx_stall_pct = 0;
                1:       rx_stall_pct = 25;
                2:       rx_stall_pct = 60;
                default: rx_stall_pct = 90;
            endcase
        end else begin
            rx_stretch--;
        end
        i_ready <= i_rst_n && !hold_off && ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // long receiver hold-off so the output side fills and input backs up
    initial begin
        wait (pressure_go);
        repeat (50) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d items still expected", expected_results.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        int         ph;
        int         n_sent;
        int         i;
        int         npairs;
        int         vlen;
        bit         got;
        t_result    res;
        logic [7:0] body_bytes[$];

        clear_body();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < 26; i++) begin
            feed_byte(opening_bytes[i].data, opening_bytes[i].last, got, res);
            if (opening_bytes[i].typed) expected_results.push_back(opening_bytes[i].want);
            else if (got) expected_results.push_back(res);
        end

        for (ph = 0; ph < 8; ph++) begin
            // limits change only between bodies with nothing in flight
            i_valid <= 1'b0;
            while (expected_results.size() != 0) @(posedge i_clk);
            repeat (6) @(posedge i_clk);
            case (ph)
                0:       pressure_go = 1'b1;
                1:       set_limits(8'd0, 12'd0, 1'b0);
                2:       set_limits(8'd1, 12'd3, 1'b0);
                3:       set_limits(8'd255, 12'd4095, 1'b1);
                4:       set_limits(8'd3, 12'd12, 1'b0);
                5:       set_limits(8'($urandom_range(0, 8)), 12'($urandom_range(0, 20)), 1'b0);
                6:       set_limits(8'($urandom), 12'($urandom), 1'b1);
                default: set_limits(8'd2, 12'd1, 1'b0);
            endcase

            n_sent = 0;
            while (n_sent < 110) begin
                body_bytes.delete();
                npairs = $urandom_range(0, 4);
                repeat (npairs) begin
                    case ($urandom_range(0, 10))
                        0, 1:    body_bytes.push_back(KEY_SEND);
                        2:       body_bytes.push_back(KEY_RECV);
                        3, 4:    body_bytes.push_back(KEY_TO);
                        5, 6, 7: begin
                            body_bytes.push_back(KEY_MSG[7:0]);
                            body_bytes.push_back(KEY_MSG[15:8]);
                        end
                        8:       repeat ($urandom_range(1, 3)) body_bytes.push_back(8'($urandom));
                        9: begin
                            // three-byte key that starts like text
                            body_bytes.push_back(KEY_MSG[7:0]);
                            body_bytes.push_back(KEY_MSG[15:8]);
                            body_bytes.push_back(KEY_TO);
                        end
                        default: ;
                    endcase
                    body_bytes.push_back(DELIM_FIRST);
                    body_bytes.push_back(DELIM_SECOND);
                    vlen = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(0, 8);
                    repeat (vlen) begin
                        body_bytes.push_back(($urandom_range(0, 7) == 0) ? DELIM_FIRST
                                                                         : 8'($urandom));
                    end
                    body_bytes.push_back(DELIM_FIRST);
                    body_bytes.push_back(DELIM_SECOND);
                end
                if ($urandom_range(0, 9) == 0) begin
                    // broken body: cut short or trailing junk
                    if (body_bytes.size() > 0 && $urandom_range(0, 1) == 0) begin
                        vlen = $urandom_range(1, body_bytes.size());
                        while (body_bytes.size() > vlen) void'(body_bytes.pop_back());
                    end else begin
                        repeat ($urandom_range(3, 6)) body_bytes.push_back(8'($urandom));
                    end
                end else begin
                    repeat ($urandom_range(0, 2)) body_bytes.push_back(8'($urandom));
                end
                if (body_bytes.size() == 0) body_bytes.push_back(8'($urandom));

                for (i = 0; i < body_bytes.size(); i++) begin
                    feed_byte(body_bytes[i], i == body_bytes.size() - 1, got, res);
                    if (got) expected_results.push_back(res);
                end
                n_sent += body_bytes.size();
            end
        end

        i_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
